/* hw/rtl/fncs_pkg.sv */
// Shared types, constants and direction tables of the fluid neighbor cell selector.
`timescale 1ns / 1ps

package fncs_pkg;

  localparam int unsigned COORD_LIMIT = 1024;
  localparam int unsigned COORD_W     = $clog2(COORD_LIMIT);
  localparam int unsigned SIZE_W      = COORD_W + 1;
  localparam int unsigned WIN_W       = 64;
  localparam int unsigned NUM_DIR     = 26;
  localparam int unsigned DIR_W       = $clog2(NUM_DIR);
  localparam int unsigned CFG_IDX_W   = 2;

  // Byte-padded widths of the stream payloads.
  localparam int unsigned IN_BITS     = 3 * COORD_W + WIN_W;
  localparam int unsigned IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = 3 * 2 + 3 * COORD_W + DIR_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X = 2'd0,
    CFG_GRID_Y = 2'd1,
    CFG_GRID_Z = 2'd2
  } cfg_reg_e;

  localparam logic signed [1:0] STEP_NEG  = -2'sd1;
  localparam logic signed [1:0] STEP_ZERO = 2'sd0;
  localparam logic signed [1:0] STEP_POS  = 2'sd1;

  typedef struct packed {
    logic signed [1:0] sx;
    logic signed [1:0] sy;
    logic signed [1:0] sz;
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } node_t;

  typedef struct packed {
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] z;
  } grid_t;

  // Range check results of one axis for the three step values.
  typedef struct packed {
    logic pos;
    logic zero;
    logic neg;
  } axis_ok_t;

  typedef struct packed {
    node_t              node;
    logic [NUM_DIR-1:0] cand;
  } cand_t;

  typedef struct packed {
    node_t            node;
    logic             found;
    logic [DIR_W-1:0] dir;
  } pick_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       offset_x;
    logic [1:0]       offset_y;
    logic [1:0]       offset_z;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [DIR_W-1:0] dir;
  } result_t;

  function automatic step_t mk_step(logic signed [1:0] sx, logic signed [1:0] sy,
                                    logic signed [1:0] sz);
    step_t s;
    s.sx = sx;
    s.sy = sy;
    s.sz = sz;
    return s;
  endfunction

  // Search order: faces, then edges, then corners.
  function automatic step_t dir_step(logic [DIR_W-1:0] k);
    step_t s;
    case (k)
      5'd0:    s = mk_step(STEP_NEG,  STEP_ZERO, STEP_ZERO);
      5'd1:    s = mk_step(STEP_POS,  STEP_ZERO, STEP_ZERO);
      5'd2:    s = mk_step(STEP_ZERO, STEP_NEG,  STEP_ZERO);
      5'd3:    s = mk_step(STEP_ZERO, STEP_POS,  STEP_ZERO);
      5'd4:    s = mk_step(STEP_ZERO, STEP_ZERO, STEP_NEG);
      5'd5:    s = mk_step(STEP_ZERO, STEP_ZERO, STEP_POS);
      5'd6:    s = mk_step(STEP_NEG,  STEP_POS,  STEP_ZERO);
      5'd7:    s = mk_step(STEP_POS,  STEP_POS,  STEP_ZERO);
      5'd8:    s = mk_step(STEP_NEG,  STEP_NEG,  STEP_ZERO);
      5'd9:    s = mk_step(STEP_POS,  STEP_NEG,  STEP_ZERO);
      5'd10:   s = mk_step(STEP_NEG,  STEP_ZERO, STEP_NEG);
      5'd11:   s = mk_step(STEP_POS,  STEP_ZERO, STEP_NEG);
      5'd12:   s = mk_step(STEP_ZERO, STEP_NEG,  STEP_NEG);
      5'd13:   s = mk_step(STEP_ZERO, STEP_POS,  STEP_NEG);
      5'd14:   s = mk_step(STEP_NEG,  STEP_ZERO, STEP_POS);
      5'd15:   s = mk_step(STEP_POS,  STEP_ZERO, STEP_POS);
      5'd16:   s = mk_step(STEP_ZERO, STEP_NEG,  STEP_POS);
      5'd17:   s = mk_step(STEP_ZERO, STEP_POS,  STEP_POS);
      5'd18:   s = mk_step(STEP_NEG,  STEP_POS,  STEP_POS);
      5'd19:   s = mk_step(STEP_POS,  STEP_POS,  STEP_POS);
      5'd20:   s = mk_step(STEP_POS,  STEP_NEG,  STEP_POS);
      5'd21:   s = mk_step(STEP_NEG,  STEP_NEG,  STEP_POS);
      5'd22:   s = mk_step(STEP_NEG,  STEP_POS,  STEP_NEG);
      5'd23:   s = mk_step(STEP_POS,  STEP_POS,  STEP_NEG);
      5'd24:   s = mk_step(STEP_POS,  STEP_NEG,  STEP_NEG);
      5'd25:   s = mk_step(STEP_NEG,  STEP_NEG,  STEP_NEG);
      default: s = mk_step(STEP_ZERO, STEP_ZERO, STEP_ZERO);
    endcase
    return s;
  endfunction

  // Window bits covered by the 2x2x2 cell of one step.
  function automatic logic [WIN_W-1:0] cell_mask(step_t s);
    logic [WIN_W-1:0] m;
    int               bit_idx;
    m = '0;
    for (int c = 0; c < 2; c++) begin
      for (int b = 0; b < 2; b++) begin
        for (int a = 0; a < 2; a++) begin
          bit_idx = (int'(s.sz) + c + 1) * 16 + (int'(s.sy) + b + 1) * 4
                    + (int'(s.sx) + a + 1);
          m[bit_idx] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/fluid_neighbor_cell_select.sv */
// Throughput: one beat per cycle unless m_axis_tready stalls the output; three
// register stages (check, pick, form) each advance whenever their own register
// is empty or is being drained.
// Reset clears every stage valid bit and sets all three grid sizes to 1024.
// Configuration writes are taken in any cycle and act on the next input beat.
`timescale 1ns / 1ps

module fluid_neighbor_cell_select (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: node_x, node_y, node_z, solid_window, zero pad.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fncs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tdata: offset_x, offset_y, offset_z, cell_x, cell_y, cell_z, direction_index, zero pad.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fncs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: found.
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fncs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fncs_pkg::SIZE_W-1:0]       cfg_data_i
);

  localparam int unsigned CW = fncs_pkg::COORD_W;

  fncs_pkg::grid_t   grid_q;
  fncs_pkg::node_t   node;
  fncs_pkg::cand_t   cand;
  fncs_pkg::pick_t   pick;
  fncs_pkg::result_t res;
  logic              check_valid, check_ready;
  logic              pick_valid, pick_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q.x <= fncs_pkg::SIZE_W'(fncs_pkg::COORD_LIMIT);
      grid_q.y <= fncs_pkg::SIZE_W'(fncs_pkg::COORD_LIMIT);
      grid_q.z <= fncs_pkg::SIZE_W'(fncs_pkg::COORD_LIMIT);
    end else if (cfg_valid_i) begin
      case (fncs_pkg::cfg_reg_e'(cfg_index_i))
        fncs_pkg::CFG_GRID_X: grid_q.x <= cfg_data_i;
        fncs_pkg::CFG_GRID_Y: grid_q.y <= cfg_data_i;
        fncs_pkg::CFG_GRID_Z: grid_q.z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign node.x = s_axis_tdata[CW-1:0];
  assign node.y = s_axis_tdata[2*CW-1:CW];
  assign node.z = s_axis_tdata[3*CW-1:2*CW];

  fncs_check u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .node_i   (node),
    .window_i (s_axis_tdata[3*CW+fncs_pkg::WIN_W-1:3*CW]),
    .grid_i   (grid_q),
    .valid_o  (check_valid),
    .ready_i  (check_ready),
    .cand_o   (cand)
  );

  fncs_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (check_valid),
    .ready_o (check_ready),
    .cand_i  (cand),
    .valid_o (pick_valid),
    .ready_i (pick_ready),
    .pick_o  (pick)
  );

  fncs_form u_form (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pick_valid),
    .ready_o  (pick_ready),
    .pick_i   (pick),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res)
  );

  assign m_axis_tuser = res.found;
  assign m_axis_tdata = {(fncs_pkg::OUT_DATA_W - fncs_pkg::OUT_BITS)'(0),
                         res.dir, res.cell_z, res.cell_y, res.cell_x,
                         res.offset_z, res.offset_y, res.offset_x};

  // A beat without a cell carries all-zero fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss beat carries nonzero fields");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (res.dir < fncs_pkg::DIR_W'(fncs_pkg::NUM_DIR)))
    else $error("direction index out of range");

  // Offsets are -1, 0 or +1 and never all zero on a hit.
  a_offset_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (res.offset_x != 2'b10 && res.offset_y != 2'b10 && res.offset_z != 2'b10 &&
       (res.offset_x != 2'b00 || res.offset_y != 2'b00 || res.offset_z != 2'b00)))
    else $error("bad offset code");

  // The six face directions move along exactly one axis.
  a_face_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && res.dir < fncs_pkg::DIR_W'(6)) |->
      ($countones({res.offset_x != 2'b00, res.offset_y != 2'b00,
                   res.offset_z != 2'b00}) == 1))
    else $error("face direction with more than one offset");

endmodule

/* hw/rtl/fncs_check.sv */
// First stage: per-axis range checks and per-direction fluid tests.
`timescale 1ns / 1ps

module fncs_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  fncs_pkg::node_t              node_i,
  input  logic [fncs_pkg::WIN_W-1:0]   window_i,
  input  fncs_pkg::grid_t              grid_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output fncs_pkg::cand_t              cand_o
);

  fncs_pkg::axis_ok_t ok_x, ok_y, ok_z;
  fncs_pkg::cand_t    cand_d, cand_q;
  logic               valid_q;

  function automatic fncs_pkg::axis_ok_t axis_check(logic [fncs_pkg::COORD_W-1:0] coord,
                                                    logic [fncs_pkg::SIZE_W-1:0]  size);
    fncs_pkg::axis_ok_t       r;
    logic [fncs_pkg::SIZE_W-1:0] c;
    c      = {1'b0, coord};
    r.neg  = (coord != '0) && ((c - fncs_pkg::SIZE_W'(1)) < size);
    r.zero = c < size;
    r.pos  = (c + fncs_pkg::SIZE_W'(2)) < size;
    return r;
  endfunction

  function automatic logic axis_sel(logic signed [1:0] s, fncs_pkg::axis_ok_t ok);
    logic r;
    case (s)
      fncs_pkg::STEP_NEG:  r = ok.neg;
      fncs_pkg::STEP_ZERO: r = ok.zero;
      fncs_pkg::STEP_POS:  r = ok.pos;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  assign ok_x = axis_check(node_i.x, grid_i.x);
  assign ok_y = axis_check(node_i.y, grid_i.y);
  assign ok_z = axis_check(node_i.z, grid_i.z);

  assign cand_d.node = node_i;

  for (genvar k = 0; k < fncs_pkg::NUM_DIR; k++) begin : g_dir
    localparam fncs_pkg::step_t Step = fncs_pkg::dir_step(fncs_pkg::DIR_W'(k));
    localparam logic [fncs_pkg::WIN_W-1:0] Mask = fncs_pkg::cell_mask(Step);
    assign cand_d.cand[k] = axis_sel(Step.sx, ok_x) & axis_sel(Step.sy, ok_y)
                            & axis_sel(Step.sz, ok_z) & ~|(window_i & Mask);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign cand_o  = cand_q;

endmodule

/* hw/rtl/fncs_pick.sv */
// Second stage: priority pick of the first passing direction.
`timescale 1ns / 1ps

module fncs_pick (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  fncs_pkg::cand_t cand_i,
  output logic            valid_o,
  input  logic            ready_i,
  output fncs_pkg::pick_t pick_o
);

  logic [fncs_pkg::NUM_DIR-1:0] first;
  fncs_pkg::pick_t              pick_d, pick_q;
  logic                         valid_q;

  // Isolate the lowest set bit, then encode its position with OR trees.
  assign first = cand_i.cand & (~cand_i.cand + fncs_pkg::NUM_DIR'(1));

  always_comb begin
    pick_d.node  = cand_i.node;
    pick_d.found = |cand_i.cand;
    pick_d.dir   = '0;
    for (int k = 0; k < fncs_pkg::NUM_DIR; k++) begin
      pick_d.dir = pick_d.dir | ({fncs_pkg::DIR_W{first[k]}} & fncs_pkg::DIR_W'(k));
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pick_q <= pick_d;
    end
  end

  assign valid_o = valid_q;
  assign pick_o  = pick_q;

endmodule

/* hw/rtl/fncs_form.sv */
// Third stage: cell base and offsets of the chosen direction, held in the output register.
`timescale 1ns / 1ps

module fncs_form (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  fncs_pkg::pick_t   pick_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fncs_pkg::result_t result_o
);

  fncs_pkg::step_t   step;
  fncs_pkg::result_t res_d, res_q;
  logic              valid_q;

  // The base wraps modulo the coordinate range.
  function automatic logic [fncs_pkg::COORD_W-1:0] base(
      logic [fncs_pkg::COORD_W-1:0] coord, logic signed [1:0] s);
    return coord + {{(fncs_pkg::COORD_W-2){s[1]}}, s};
  endfunction

  assign step = fncs_pkg::dir_step(pick_i.dir);

  always_comb begin
    res_d = '0;
    if (pick_i.found) begin
      res_d.found    = 1'b1;
      res_d.offset_x = 2'(-step.sx);
      res_d.offset_y = 2'(-step.sy);
      res_d.offset_z = 2'(-step.sz);
      res_d.cell_x   = base(pick_i.node.x, step.sx);
      res_d.cell_y   = base(pick_i.node.y, step.sy);
      res_d.cell_z   = base(pick_i.node.z, step.sz);
      res_d.dir      = pick_i.dir;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule
